>>> hdl/npc_pkg.sv
// Shared types and constants for the nearest palette color search block.
package npc_pkg;

  localparam int CHAN_W = 8;
  localparam int DIST_W = 18;

  // Request action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CHAN_W-1:0] entry_index;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] best_index;
    logic [CHAN_W-1:0] best_red;
    logic [CHAN_W-1:0] best_green;
    logic [CHAN_W-1:0] best_blue;
    logic [DIST_W-1:0] best_distance;
    logic              exact_hit;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic take_req;   // request beat accepted this cycle
    logic clear_wr;   // write zero at sweep address, advance
    logic scan_rd;    // read palette at sweep address, advance
    logic load_out;   // move best match into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;   // sweep address is the last entry
    logic pipe_busy;  // distance pipeline still holds entries
    logic slot_free;  // output register can take a result this cycle
  } stat_t;

endpackage

>>> hdl/npc_ctrl.sv
// Sequencer for palette clearing, loading and query scans.
module npc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_action,
  output logic           req_stall,
  input  npc_pkg::stat_t stat,
  output npc_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd.take_req = 1'b0;
    cmd.clear_wr = 1'b0;
    cmd.scan_rd  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.take_req = req_valid;
        if (req_valid && req_action == npc_pkg::ACT_QUERY) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.cnt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/npc_dp.sv
// Palette memory, sweep counter, distance pipeline and result register.
module npc_dp #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  npc_pkg::req_t  req,
  input  npc_pkg::cmd_t  cmd,
  output npc_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output npc_pkg::rsp_t  rsp
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = npc_pkg::CHAN_W;
  localparam int DW = npc_pkg::DIST_W;
  localparam int EW = 3 * CW;

  logic [EW-1:0] mem [PALETTE_ENTRIES];

  logic [AW-1:0] cnt;
  logic          cnt_step;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // query color
  logic [CW-1:0] q_r, q_g, q_b;

  // stage 1: read data
  logic          v1;
  logic          first1;
  logic [CW-1:0] idx1;
  logic [EW-1:0] rdata;

  // stage 2: squared channel differences
  logic          v2;
  logic          first2;
  logic [CW-1:0] idx2;
  logic [EW-1:0] ent2;
  logic [2*CW-1:0] sq_r, sq_g, sq_b;

  // running best
  logic [DW-1:0] best_d;
  logic [CW-1:0] best_i;
  logic [EW-1:0] best_e;

  logic [CW-1:0] dr, dg, db;
  logic [DW-1:0] dist_sum;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign cnt_step = cmd.clear_wr || cmd.scan_rd;

  assign stat.cnt_last  = (cnt == AW'(PALETTE_ENTRIES - 1));
  assign stat.pipe_busy = v1 || v2;
  assign stat.slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cnt_step) begin
      cnt <= stat.cnt_last ? '0 : cnt + 1'b1;
    end
  end

  // writes beyond the palette are dropped
  assign wr_en = cmd.clear_wr ||
                 (cmd.take_req && req.action == npc_pkg::ACT_LOAD &&
                  (32'(req.entry_index) < PALETTE_ENTRIES));
  assign wr_addr = cmd.clear_wr ? cnt : AW'(req.entry_index);
  assign wr_data = cmd.clear_wr ? '0 : {req.red_in, req.green_in, req.blue_in};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.scan_rd) rdata <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req && req.action == npc_pkg::ACT_QUERY) begin
      q_r <= req.red_in;
      q_g <= req.green_in;
      q_b <= req.blue_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= (cnt == '0);
    idx1   <= CW'(cnt);
  end

  assign dr = abs_diff(rdata[EW-1 -: CW], q_r);
  assign dg = abs_diff(rdata[2*CW-1 -: CW], q_g);
  assign db = abs_diff(rdata[CW-1:0], q_b);

  always_ff @(posedge clk) begin
    if (v1) begin
      sq_r   <= dr * dr;
      sq_g   <= dg * dg;
      sq_b   <= db * db;
      first2 <= first1;
      idx2   <= idx1;
      ent2   <= rdata;
    end
  end

  assign dist_sum = DW'(sq_r) + DW'(sq_g) + DW'(sq_b);

  // strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (v2 && (first2 || dist_sum < best_d)) begin
      best_d <= dist_sum;
      best_i <= idx2;
      best_e <= ent2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.best_index    <= best_i;
      rsp.best_red      <= best_e[EW-1 -: CW];
      rsp.best_green    <= best_e[2*CW-1 -: CW];
      rsp.best_blue     <= best_e[CW-1:0];
      rsp.best_distance <= best_d;
      rsp.exact_hit     <= (best_d == '0);
    end
  end

endmodule

>>> hdl/nearest_palette_color_search.sv
// Top level of the nearest palette color search block.
//
//   channel  dir  handshake              beat
//   req      in   req_valid / req_stall  load one entry, or query one color
//   rsp      out  rsp_valid / rsp_stall  best entry for a query
//
// A load beat is written to the palette as it is taken. A query reads one
// palette entry per cycle from the single-port memory, and the next request
// is taken in the same cycle that the result becomes valid. After reset a
// clearing pass zeroes the memory with req_stall high. A stalled result waits
// in the output register; loads are still taken, and the following query
// holds its result until it drains.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  npc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output npc_pkg::rsp_t rsp
);

  npc_pkg::cmd_t  cmd;
  npc_pkg::stat_t stat;

  npc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .req_stall  (req_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  npc_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.slot_free)
    else $error("result loaded over a waiting beat");

  a_load_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !stat.pipe_busy)
    else $error("result loaded before the scan drained");

  a_scan_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_rd || cmd.clear_wr) |-> req_stall)
    else $error("request taken during a sweep");

  a_exact_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.exact_hit == (rsp.best_distance == '0)))
    else $error("exact_hit disagrees with distance");
`endif

endmodule
